[src/windowed_peak_level_normalizer_assert.svh]
// assertion macros shared by the normalizer rtl
// expects signals named clk and rst_n in the including module
`ifndef WINDOWED_PEAK_LEVEL_NORMALIZER_ASSERT_SVH
`define WINDOWED_PEAK_LEVEL_NORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define WPLN_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("wpln assertion failed");
// next-cycle implication, checked out of reset
`define WPLN_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("wpln assertion failed");
`else
`define WPLN_ASSERT_IMP(label, pre, post)
`define WPLN_ASSERT_NXT(label, pre, post)
`endif

`endif

[src/wpln_pkg.sv]
// shared types and constants of the windowed peak level normalizer
// no dependencies
`default_nettype none

package wpln_pkg;

  localparam int unsigned IN_ENERGY_W = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned LEVEL_W     = 15;

  // 100 percent in units of 1/256 percent
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'd25600;
  localparam logic [WIN_W-1:0]   WIN_RESET  = 16'd200;

  // quotient bits produced by the serial divider, one per cycle
  localparam int unsigned DIV_STEPS = LEVEL_W;
  localparam int unsigned DIV_CNT_W = 4;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_in;   // capture input beat
    logic rd_cur;    // read the current ring cell
    logic wr_upd;    // raise current cell with the sample
    logic adv_step;  // advance the ring if the window expired
    logic rd_scan;   // read one cell of the peak scan
    logic div_load;  // select result mode and load divider
    logic div_step;  // one restoring divide step
    logic load_out;  // write the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_needed;  // peak nonzero and sample below peak
  } status_t;

endpackage

`default_nettype wire

[src/windowed_peak_level_normalizer.sv]
// Steps: cell read, cell update, window advance, peak scan at one cell per cycle,
// then the 15-step serial divider when a division is needed (skipped when the peak
// is zero or the sample reaches the peak), and the output register load. A new beat
// is taken only in idle; a result waits in the output register until it is taken.
// Reset (rst_n, synchronous, low): ring cells read as zero via valid bits, index,
// advance time and previous level cleared, window_ms set to 200; no clearing pass.
`default_nettype none

module windowed_peak_level_normalizer #(
  parameter int unsigned NUM_CELLS   = 8,
  parameter int unsigned ENERGY_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [wpln_pkg::IN_ENERGY_W-1:0]  in_bass_energy,
  input  wire logic [wpln_pkg::TIME_W-1:0]       in_now_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [wpln_pkg::LEVEL_W-1:0]           out_level,
  output logic                                   out_level_changed,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [wpln_pkg::WIN_W-1:0]        cfg_data
);

  wpln_pkg::cmd_t                cmd;
  wpln_pkg::status_t             status;
  logic [$clog2(NUM_CELLS)-1:0]  scan_addr;

  // register writes are taken at any time
  assign cfg_ready = 1'b1;

  wpln_ctrl #(
    .NUM_CELLS (NUM_CELLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .scan_addr (scan_addr)
  );

  wpln_dp #(
    .NUM_CELLS   (NUM_CELLS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .scan_addr         (scan_addr),
    .status            (status),
    .in_bass_energy    (in_bass_energy),
    .in_now_ms         (in_now_ms),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_data          (cfg_data),
    .out_level         (out_level),
    .out_level_changed (out_level_changed)
  );

endmodule

`default_nettype wire

[src/wpln_dp.sv]
// datapath: ring cell memory, window timing, peak scan, serial divider, output register
// depends on wpln_pkg and windowed_peak_level_normalizer_assert.svh
`default_nettype none
`include "windowed_peak_level_normalizer_assert.svh"

module wpln_dp #(
  parameter int unsigned NUM_CELLS   = 8,
  parameter int unsigned ENERGY_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wpln_pkg::cmd_t                      cmd,
  input  wire logic [$clog2(NUM_CELLS)-1:0]        scan_addr,
  output wpln_pkg::status_t                        status,
  input  wire logic [wpln_pkg::IN_ENERGY_W-1:0]    in_bass_energy,
  input  wire logic [wpln_pkg::TIME_W-1:0]         in_now_ms,
  input  wire logic                                cfg_we,
  input  wire logic [wpln_pkg::WIN_W-1:0]          cfg_data,
  output logic [wpln_pkg::LEVEL_W-1:0]             out_level,
  output logic                                     out_level_changed
);

  localparam int unsigned IW = $clog2(NUM_CELLS);
  localparam int unsigned EB = ENERGY_BITS;
  localparam int unsigned PW = EB + wpln_pkg::LEVEL_W;
  localparam int unsigned LW = wpln_pkg::LEVEL_W;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_SAT  = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;

  // configuration and ring state
  logic [wpln_pkg::WIN_W-1:0]  window_r;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [wpln_pkg::TIME_W-1:0] last_r;
  logic [NUM_CELLS-1:0]        vld_r;

  // captured beat
  logic [EB-1:0]               be_r;
  logic [wpln_pkg::TIME_W-1:0] now_r;
  logic [47:0]                 be_ext;

  // memory ports
  logic [EB-1:0] cell_mem [NUM_CELLS];
  logic          we;
  logic [IW-1:0] waddr;
  logic [EB-1:0] wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [EB-1:0] rdata_r;
  logic          rvld_r;
  logic [EB-1:0] rd_val;

  // window and scan
  logic          adv_r;
  logic          acc_en_r;
  logic [EB-1:0] peak_r;

  // divider
  logic [PW-1:0] prod_r;
  logic [EB-1:0] rem_r;
  logic [LW-1:0] num_r;
  logic [LW-1:0] q_r;
  logic [1:0]    mode_r;
  logic [EB:0]   div_try;
  logic          div_ge;

  // result
  logic [LW-1:0] level_nxt;
  logic [LW-1:0] prev_r;
  logic [LW-1:0] level_r;
  logic          changed_r;

  // sample keeps its low ENERGY_BITS bits
  assign be_ext = {32'd0, in_bass_energy};

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= wpln_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_data;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      be_r  <= be_ext[EB-1:0];
      now_r <= in_now_ms;
    end
  end

  // next ring index with wrap
  assign idx_nxt = (idx_r == IW'(NUM_CELLS - 1)) ? '0 : idx_r + 1'b1;

  // cell read value, unwritten cells read as zero
  assign rd_val = rvld_r ? rdata_r : '0;

  // memory port selection
  always_comb begin
    re    = cmd.rd_cur | cmd.rd_scan;
    raddr = cmd.rd_cur ? idx_r : scan_addr;
    we    = cmd.wr_upd | (cmd.adv_step & adv_r);
    waddr = cmd.wr_upd ? idx_r : idx_nxt;
    wdata = '0;
    if (cmd.wr_upd) begin
      wdata = (be_r > rd_val) ? be_r : rd_val;
    end
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (we) begin
      cell_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= cell_mem[raddr];
    end
  end

  // cell valid bits and read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  // window check and ring advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      last_r <= '0;
    end else if (cmd.adv_step && adv_r) begin
      idx_r  <= idx_nxt;
      last_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_upd) begin
      adv_r <= (now_r - last_r) > {16'd0, window_r};
    end
  end

  // peak scan accumulator, one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.rd_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv_step) begin
      peak_r <= '0;
    end else if (acc_en_r && (rd_val > peak_r)) begin
      peak_r <= rd_val;
    end
  end

  // scaled sample, product registered ahead of the divider
  always_ff @(posedge clk) begin
    prod_r <= PW'(be_r) * PW'(wpln_pkg::FULL_SCALE);
  end

  assign status.div_needed = (peak_r != '0) && (be_r < peak_r);

  // restoring divide step
  assign div_try = {rem_r, num_r[LW-1]};
  assign div_ge  = div_try >= {1'b0, peak_r};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= prod_r[PW-1:LW];
      num_r <= prod_r[LW-1:0];
      q_r   <= '0;
      if (peak_r == '0) begin
        mode_r <= MODE_ZERO;
      end else if (be_r >= peak_r) begin
        mode_r <= MODE_SAT;
      end else begin
        mode_r <= MODE_DIV;
      end
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? EB'(div_try - {1'b0, peak_r}) : div_try[EB-1:0];
      num_r <= {num_r[LW-2:0], 1'b0};
      q_r   <= {q_r[LW-2:0], div_ge};
    end
  end

  // result selection
  always_comb begin
    unique case (mode_r)
      MODE_ZERO: level_nxt = '0;
      MODE_SAT:  level_nxt = wpln_pkg::FULL_SCALE;
      MODE_DIV:  level_nxt = q_r;
      default:   level_nxt = '0;
    endcase
  end

  // previous level and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (cmd.load_out) begin
      prev_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      level_r   <= level_nxt;
      changed_r <= level_nxt != prev_r;
    end
  end

  assign out_level         = level_r;
  assign out_level_changed = changed_r;

  // divider remainder stays below the peak
  `WPLN_ASSERT_IMP(a_rem_below_peak, cmd.div_step && mode_r == MODE_DIV, rem_r < peak_r)
  // stored level never exceeds full scale
  `WPLN_ASSERT_NXT(a_level_in_range, cmd.load_out, level_r <= wpln_pkg::FULL_SCALE)
  // zero peak gives a zero level
  `WPLN_ASSERT_NXT(a_zero_peak_level, cmd.load_out && mode_r == MODE_ZERO, level_r == '0)

endmodule

`default_nettype wire

[src/wpln_ctrl.sv]
// controller: sequences ring update, peak scan, division and output handoff
// depends on wpln_pkg and windowed_peak_level_normalizer_assert.svh
`default_nettype none
`include "windowed_peak_level_normalizer_assert.svh"

module wpln_ctrl #(
  parameter int unsigned NUM_CELLS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  input  wire wpln_pkg::status_t             status,
  output wpln_pkg::cmd_t                     cmd,
  output logic [$clog2(NUM_CELLS)-1:0]       scan_addr
);

  localparam int unsigned IW = $clog2(NUM_CELLS);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RDCUR    = 4'd1;
  localparam logic [3:0] S_UPD      = 4'd2;
  localparam logic [3:0] S_ADV      = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_SCAN_END = 4'd5;
  localparam logic [3:0] S_PREP     = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0]                   state_r, state_nxt;
  logic [IW-1:0]                scan_r, scan_nxt;
  logic [wpln_pkg::DIV_CNT_W-1:0] div_r, div_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;
  logic                         scan_last;
  logic                         div_last;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign scan_addr = scan_r;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_last = (scan_r == IW'(NUM_CELLS - 1));
  assign div_last  = (div_r == wpln_pkg::DIV_CNT_W'(wpln_pkg::DIV_STEPS - 1));

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    div_nxt   = div_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take_in = in_valid;
        if (in_valid) begin
          state_nxt = S_RDCUR;
        end
      end
      S_RDCUR: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.wr_upd = 1'b1;
        state_nxt  = S_ADV;
      end
      S_ADV: begin
        cmd.adv_step = 1'b1;
        scan_nxt     = '0;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_scan = 1'b1;
        scan_nxt    = scan_r + 1'b1;
        if (scan_last) begin
          scan_nxt  = '0;
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.div_load = 1'b1;
        div_nxt      = '0;
        state_nxt    = status.div_needed ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_nxt      = div_r + 1'b1;
        if (div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.load_out = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the beat is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      div_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      div_r       <= div_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a pending result is never overwritten
  `WPLN_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready)
  // accepted beat starts the cell read
  `WPLN_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == S_RDCUR)
  // divider runs exactly its step count
  `WPLN_ASSERT_NXT(a_div_ends, state_r == S_DIV && div_last, state_r == S_FIN)

endmodule

`default_nettype wire
